[sv/bdq_pkg.sv]
// Shared constants, codes and control structs for the bounded deque.
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned OPC_W  = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FILL_W = 7;

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_INVALID = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_PUSH_FRONT,
    DP_PUSH_BACK,
    DP_POP_FRONT,
    DP_POP_BACK,
    DP_DUMP_START,
    DP_DUMP_NEXT
  } dp_op_e;

  typedef enum logic [1:0] {
    RES_IN,
    RES_ZERO,
    RES_MEM
  } res_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_e;

  typedef struct packed {
    dp_op_e   op;
    logic     load;
    res_sel_e res_sel;
    status_e  status;
    logic     last;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic dump_last;
  } dp_stat_t;

  // Ring add of two indices, both below DEPTH.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
    logic [PTR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (PTR_W+1)'(DEPTH)) begin
      sum = sum - (PTR_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

[sv/bdq_in_if.sv]
// Input channel: opcode and value with a valid/ready handshake.
`timescale 1ns / 1ps

interface bdq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [bdq_pkg::OPC_W-1:0]             opcode;
  logic signed [bdq_pkg::DATA_W-1:0]     value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

[sv/bdq_out_if.sv]
// Output channel: result items with a valid/ready handshake.
`timescale 1ns / 1ps

interface bdq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [bdq_pkg::STAT_W-1:0]            status;
  logic signed [bdq_pkg::DATA_W-1:0]     result_value;
  logic [bdq_pkg::FILL_W-1:0]            fill_count;
  logic                                  last;

  modport source (output valid, output status, output result_value, output fill_count,
                  output last, input ready);
  modport sink   (input valid, input status, input result_value, input fill_count,
                  input last, output ready);
endinterface

[sv/bdq_dp.sv]
// Datapath: ring store, front pointer, entry count, dump index and result register.
`timescale 1ns / 1ps

module bdq_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bdq_pkg::dp_cmd_t                    cmd_i,
  input  logic signed [bdq_pkg::DATA_W-1:0]   value_i,
  output bdq_pkg::dp_stat_t                   stat_o,
  output logic [bdq_pkg::STAT_W-1:0]          status_o,
  output logic signed [bdq_pkg::DATA_W-1:0]   result_value_o,
  output logic [bdq_pkg::FILL_W-1:0]          fill_count_o,
  output logic                                last_o
);

  logic [bdq_pkg::DATA_W-1:0] mem [bdq_pkg::DEPTH];
  logic [bdq_pkg::DATA_W-1:0] rdata_q;

  logic [bdq_pkg::PTR_W-1:0] front_q, front_d;
  logic [bdq_pkg::CNT_W-1:0] count_q, count_d;
  logic [bdq_pkg::PTR_W-1:0] idx_q, idx_d;

  logic                      we, re;
  logic [bdq_pkg::PTR_W-1:0] waddr, raddr;
  logic [bdq_pkg::PTR_W-1:0] count_lo, front_dec, idx_inc;

  logic [bdq_pkg::STAT_W-1:0]        status_q;
  logic signed [bdq_pkg::DATA_W-1:0] result_q;
  logic [bdq_pkg::FILL_W-1:0]        fill_q;
  logic                              last_q;

  assign count_lo  = count_q[bdq_pkg::PTR_W-1:0];
  assign front_dec = (front_q == '0) ? bdq_pkg::PTR_W'(bdq_pkg::DEPTH - 1)
                                     : front_q - bdq_pkg::PTR_W'(1);
  assign idx_inc   = idx_q + bdq_pkg::PTR_W'(1);

  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign stat_o.dump_last = ({1'b0, idx_q} + bdq_pkg::CNT_W'(1)) == count_q;

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    idx_d   = idx_q;
    we      = 1'b0;
    re      = 1'b0;
    waddr   = front_q;
    raddr   = front_q;
    case (cmd_i.op)
      bdq_pkg::DP_PUSH_FRONT: begin
        we      = 1'b1;
        waddr   = front_dec;
        front_d = front_dec;
        count_d = count_q + bdq_pkg::CNT_W'(1);
      end
      bdq_pkg::DP_PUSH_BACK: begin
        we      = 1'b1;
        waddr   = bdq_pkg::ring_add(front_q, count_lo);
        count_d = count_q + bdq_pkg::CNT_W'(1);
      end
      bdq_pkg::DP_POP_FRONT: begin
        re      = 1'b1;
        raddr   = front_q;
        front_d = bdq_pkg::ring_add(front_q, bdq_pkg::PTR_W'(1));
        count_d = count_q - bdq_pkg::CNT_W'(1);
      end
      bdq_pkg::DP_POP_BACK: begin
        re      = 1'b1;
        raddr   = bdq_pkg::ring_add(front_q, count_lo - bdq_pkg::PTR_W'(1));
        count_d = count_q - bdq_pkg::CNT_W'(1);
      end
      bdq_pkg::DP_DUMP_START: begin
        re    = 1'b1;
        raddr = front_q;
        idx_d = '0;
      end
      bdq_pkg::DP_DUMP_NEXT: begin
        re    = 1'b1;
        raddr = bdq_pkg::ring_add(front_q, idx_inc);
        idx_d = idx_inc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= value_i;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Result register; fill count follows the update of this cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= cmd_i.status;
      last_q   <= cmd_i.last;
      fill_q   <= bdq_pkg::FILL_W'(count_d);
      case (cmd_i.res_sel)
        bdq_pkg::RES_IN:  result_q <= value_i;
        bdq_pkg::RES_MEM: result_q <= rdata_q;
        default:          result_q <= '0;
      endcase
    end
  end

  assign status_o       = status_q;
  assign result_value_o = result_q;
  assign fill_count_o   = fill_q;
  assign last_o         = last_q;

endmodule

[sv/bdq_ctrl.sv]
// Controller: decodes opcodes, sequences reads and dumps, runs both handshakes.
`timescale 1ns / 1ps

module bdq_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [bdq_pkg::OPC_W-1:0]  opcode_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  bdq_pkg::dp_stat_t          stat_i,
  output bdq_pkg::dp_cmd_t           cmd_o
);

  bdq_pkg::state_e state_q, state_d;
  logic            dump_q, dump_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdq_pkg::ST_IDLE;
      dump_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      dump_q  <= dump_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    dump_d        = dump_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.op      = bdq_pkg::DP_NONE;
    cmd_o.load    = 1'b0;
    cmd_o.res_sel = bdq_pkg::RES_ZERO;
    cmd_o.status  = bdq_pkg::STAT_OK;
    cmd_o.last    = 1'b1;
    case (state_q)
      bdq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dump_d = 1'b0;
          case (bdq_pkg::opcode_e'(opcode_i))
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
              cmd_o.load    = 1'b1;
              cmd_o.res_sel = bdq_pkg::RES_IN;
              state_d       = bdq_pkg::ST_OUT;
              if (stat_i.full) begin
                cmd_o.status = bdq_pkg::STAT_FULL;
              end else if (bdq_pkg::opcode_e'(opcode_i) == bdq_pkg::OP_PUSH_FRONT) begin
                cmd_o.op = bdq_pkg::DP_PUSH_FRONT;
              end else begin
                cmd_o.op = bdq_pkg::DP_PUSH_BACK;
              end
            end
            bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK, bdq_pkg::OP_DUMP: begin
              if (stat_i.empty) begin
                cmd_o.load   = 1'b1;
                cmd_o.status = bdq_pkg::STAT_EMPTY;
                state_d      = bdq_pkg::ST_OUT;
              end else begin
                state_d = bdq_pkg::ST_READ;
                case (bdq_pkg::opcode_e'(opcode_i))
                  bdq_pkg::OP_POP_FRONT: cmd_o.op = bdq_pkg::DP_POP_FRONT;
                  bdq_pkg::OP_POP_BACK:  cmd_o.op = bdq_pkg::DP_POP_BACK;
                  default: begin
                    cmd_o.op = bdq_pkg::DP_DUMP_START;
                    dump_d   = 1'b1;
                  end
                endcase
              end
            end
            default: begin
              cmd_o.load   = 1'b1;
              cmd_o.status = bdq_pkg::STAT_INVALID;
              state_d      = bdq_pkg::ST_OUT;
            end
          endcase
        end
      end
      bdq_pkg::ST_READ: begin
        // Capture the registered read data into the result register.
        cmd_o.load    = 1'b1;
        cmd_o.res_sel = bdq_pkg::RES_MEM;
        cmd_o.last    = !dump_q || stat_i.dump_last;
        state_d       = bdq_pkg::ST_OUT;
      end
      bdq_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (dump_q && !stat_i.dump_last) begin
            cmd_o.op = bdq_pkg::DP_DUMP_NEXT;
            state_d  = bdq_pkg::ST_READ;
          end else begin
            dump_d  = 1'b0;
            state_d = bdq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = bdq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/bounded_deque.sv]
// Top level of the bounded deque: controller plus datapath.
//
//   channel  | dir | handshake     | payload
//   in_ch    | in  | valid / ready | opcode[2:0], value[31:0] signed
//   out_ch   | out | valid / ready | status[1:0], result_value[31:0] signed,
//            |     |               | fill_count[6:0], last
//
// Push, invalid opcode and any empty case: result valid in the cycle after the transfer in.
// Pop: a read state comes first, as the ring store has one read port with registered data.
// Dump: stored entries are read and output in turn, front first; one operation at a time.
// Reset clears the pointers, the count and the controller; the store is not cleared.
// A stalled result holds in the output register and no new input is taken meanwhile.
`timescale 1ns / 1ps

module bounded_deque (
  input  logic             clk_i,
  input  logic             rst_ni,
  bdq_in_if.sink           in_ch,
  bdq_out_if.source        out_ch
);

  bdq_pkg::dp_cmd_t  cmd;
  bdq_pkg::dp_stat_t stat;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .opcode_i    (in_ch.opcode),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bdq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .value_i        (in_ch.value),
    .stat_o         (stat),
    .status_o       (out_ch.status),
    .result_value_o (out_ch.result_value),
    .fill_count_o   (out_ch.fill_count),
    .last_o         (out_ch.last)
  );

endmodule
